[rtl/core/rsip_pkg.sv]
package rsip_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int RADIX_W = CHAR_W + 1;
  localparam int DIGIT_W = CHAR_W + 2;
  localparam int PROD_W  = VALUE_W + DIGIT_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int INDEX_W = 2;

  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic signed [SUM_W-1:0] VALUE_MAX = 43'sd2147483647;
  localparam logic signed [SUM_W-1:0] VALUE_MIN = -43'sd2147483648;

  localparam logic [INDEX_W-1:0] REG_LOW_CHAR     = 2'd0;
  localparam logic [INDEX_W-1:0] REG_HIGH_CHAR    = 2'd1;
  localparam logic [INDEX_W-1:0] REG_DIGIT_OFFSET = 2'd2;

  localparam logic [CHAR_W-1:0] LOW_CHAR_RST     = 8'd48;
  localparam logic [CHAR_W-1:0] HIGH_CHAR_RST    = 8'd57;
  localparam logic [CHAR_W-1:0] DIGIT_OFFSET_RST = 8'd0;

  typedef struct packed {
    logic [CHAR_W-1:0] low_char;
    logic [CHAR_W-1:0] high_char;
    logic [CHAR_W-1:0] digit_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] acc;
    logic                      negative;
    logic                      at_start;
    logic                      seen_body;
    logic                      error_seen;
  } state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      ok;
  } res_t;

  localparam state_t STATE_CLEAR = '{
    acc:        '0,
    negative:   1'b0,
    at_start:   1'b1,
    seen_body:  1'b0,
    error_seen: 1'b0
  };

endpackage

[rtl/core/rsip_step.sv]
// Next-state logic for one character: sign, range check, multiply-accumulate,
// overflow check, and the result on a terminator.
module rsip_step (
  input  rsip_pkg::cfg_t                  cfg,
  input  rsip_pkg::state_t                cur,
  input  logic [rsip_pkg::CHAR_W-1:0]     char_code,
  output rsip_pkg::state_t                nxt,
  output logic                            emit,
  output rsip_pkg::res_t                  res
);

  logic [rsip_pkg::RADIX_W-1:0]        radix;
  logic [rsip_pkg::DIGIT_W-1:0]        digit;
  logic signed [rsip_pkg::DIGIT_W:0]   digit_s;
  logic signed [rsip_pkg::PROD_W-1:0]  prod;
  logic signed [rsip_pkg::SUM_W-1:0]   sum;
  logic                                in_range;
  logic                                is_sign;
  logic                                ovf;

  assign radix = {1'b0, cfg.high_char} - {1'b0, cfg.low_char} + rsip_pkg::RADIX_W'(1);
  assign digit = rsip_pkg::DIGIT_W'(char_code - cfg.low_char)
               + rsip_pkg::DIGIT_W'(cfg.digit_offset);
  assign digit_s = cur.negative ? -$signed({1'b0, digit}) : $signed({1'b0, digit});
  assign prod = cur.acc * $signed({1'b0, radix});
  assign sum  = {prod[rsip_pkg::PROD_W-1], prod}
              + {{(rsip_pkg::SUM_W-rsip_pkg::DIGIT_W-1){digit_s[rsip_pkg::DIGIT_W]}},
                 digit_s};

  assign in_range = (char_code >= cfg.low_char) && (char_code <= cfg.high_char);
  assign is_sign  = cur.at_start
                  && (char_code == rsip_pkg::CHAR_PLUS || char_code == rsip_pkg::CHAR_MINUS);
  assign ovf      = cur.negative ? (sum < rsip_pkg::VALUE_MIN) : (sum > rsip_pkg::VALUE_MAX);

  always_comb begin
    nxt       = cur;
    emit      = 1'b0;
    res.ok    = !cur.error_seen && cur.seen_body;
    res.value = res.ok ? cur.acc : '0;
    if (char_code == rsip_pkg::CHAR_NUL) begin
      emit = 1'b1;
      nxt  = rsip_pkg::STATE_CLEAR;
    end else if (!cur.error_seen) begin
      nxt.at_start = 1'b0;
      if (is_sign) begin
        nxt.negative = (char_code == rsip_pkg::CHAR_MINUS);
      end else if (!in_range || ovf) begin
        nxt.error_seen = 1'b1;
        nxt.acc        = '0;
      end else begin
        nxt.acc       = sum[rsip_pkg::VALUE_W-1:0];
        nxt.seen_body = 1'b1;
      end
    end
  end

endmodule

[rtl/core/radix_string_to_int_parser.sv]
// Radix string-to-integer parser. One character byte per item on s_axis, one
// result per zero terminator on m_axis (value in tdata, valid flag in tuser;
// value is 0 when the string was empty, a bare sign, out of range or
// overflowed). Throughput is one character per cycle while no terminator
// waits; the m_axis result is registered. The per-cycle path is the 32x9
// multiply-accumulate with the signed 32-bit overflow compare on the state
// registers. A terminator waits in the input register only while the
// previous result is still held unread. Configuration writes (cfg_index 0
// low char, 1 high char, 2 digit offset) must be made while the block is idle.
module radix_string_to_int_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [rsip_pkg::INDEX_W-1:0]       cfg_index,
  input  logic [rsip_pkg::CHAR_W-1:0]        cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rsip_pkg::CHAR_W-1:0]        s_axis_tdata,   // [7:0] char_code
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rsip_pkg::VALUE_W-1:0]       m_axis_tdata,   // [31:0] value
  output logic                               m_axis_tuser    // [0] valid_res
);

  rsip_pkg::cfg_t   cfg;
  rsip_pkg::state_t st;
  rsip_pkg::state_t st_next;
  rsip_pkg::res_t   res;
  logic             emit;

  logic                        in_valid;
  logic [rsip_pkg::CHAR_W-1:0] in_char;
  logic                        advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_char     <= rsip_pkg::LOW_CHAR_RST;
      cfg.high_char    <= rsip_pkg::HIGH_CHAR_RST;
      cfg.digit_offset <= rsip_pkg::DIGIT_OFFSET_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        rsip_pkg::REG_LOW_CHAR:     cfg.low_char     <= cfg_data;
        rsip_pkg::REG_HIGH_CHAR:    cfg.high_char    <= cfg_data;
        rsip_pkg::REG_DIGIT_OFFSET: cfg.digit_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // terminator needs a free output slot; other characters always move on
  assign advance = in_valid
                && (in_char != rsip_pkg::CHAR_NUL || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
    end
  end

  rsip_step u_step (
    .cfg       (cfg),
    .cur       (st),
    .char_code (in_char),
    .nxt       (st_next),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rsip_pkg::STATE_CLEAR;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_axis_tdata <= res.value;
      m_axis_tuser <= res.ok;
    end
  end

`ifndef SYNTHESIS
  a_invalid_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result carries nonzero value");

  a_error_clears_acc: assert property (@(posedge clk) disable iff (rst)
    st.error_seen |-> st.acc == '0)
    else $error("accumulator nonzero after error");

  a_positive_acc: assert property (@(posedge clk) disable iff (rst)
    !st.negative |-> !st.acc[rsip_pkg::VALUE_W-1])
    else $error("positive string accumulated a negative value");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_char == rsip_pkg::CHAR_NUL |=> st.at_start && !st.error_seen
      && m_axis_tvalid)
    else $error("terminator did not clear state or emit a result");
`endif

endmodule
